[rtl/bcee_pkg.sv]
`timescale 1ns / 1ps

package bcee_pkg;

	localparam int POINTS = 64;
	localparam int TYPES  = 3;
	localparam int TYPE_W = 2;
	localparam int IDX_W  = $clog2(POINTS);
	localparam int CNT_W  = 7;
	localparam int WORD_W = 64;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} scan_state_t;

	typedef struct packed {
		logic              en;
		logic [TYPE_W-1:0] sel;
		logic [POINTS-1:0] data;
	} mask_wr_t;

	function automatic logic [POINTS-1:0] limit_mask(input logic [CNT_W-1:0] cnt);
		logic [POINTS-1:0] m;
		for (int i = 0; i < POINTS; i++) begin
			m[i] = (CNT_W'(i) < cnt);
		end
		return m;
	endfunction

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		priority if (v == '0) begin
			r = CNT_W'(1);
		end else if (v > CNT_W'(POINTS)) begin
			r = CNT_W'(POINTS);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[rtl/bcee_mask_store.sv]
`timescale 1ns / 1ps

module bcee_mask_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bcee_pkg::mask_wr_t         wr,
	input  logic [bcee_pkg::TYPE_W-1:0] rd_sel,
	output logic [bcee_pkg::POINTS-1:0] rd_mask
);
	import bcee_pkg::*;

	logic [POINTS-1:0] masks_q [TYPES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TYPES; t++) begin
				masks_q[t] <= '0;
			end
		end else if (wr.en && (int'(wr.sel) < TYPES)) begin
			masks_q[wr.sel] <= wr.data;
		end
	end

	assign rd_mask = (int'(rd_sel) < TYPES) ? masks_q[rd_sel] : '0;

endmodule

[rtl/bcee_scan.sv]
`timescale 1ns / 1ps

module bcee_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bcee_pkg::CNT_W-1:0]  pc,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [bcee_pkg::TYPE_W-1:0] prot_type,
	input  logic [bcee_pkg::WORD_W-1:0] new_bits,
	input  logic [bcee_pkg::POINTS-1:0] rd_mask,
	output bcee_pkg::mask_wr_t          wr,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bcee_pkg::TYPE_W-1:0] event_type,
	output logic [bcee_pkg::IDX_W-1:0]  point_index,
	output logic                        new_value,
	output logic [bcee_pkg::WORD_W-1:0] mask_after,
	output logic                        last
);
	import bcee_pkg::*;

	scan_state_t       state_q, state_d;
	logic [POINTS-1:0] diff_q, word_q;
	logic [TYPE_W-1:0] type_q;
	logic [IDX_W-1:0]  idx_q;

	logic              out_valid_q;
	logic [TYPE_W-1:0] ev_type_q;
	logic [IDX_W-1:0]  pidx_q;
	logic              nval_q;
	logic [POINTS-1:0] mask_q;
	logic              last_q;

	logic              accept, type_ok, slot_free, emit, advance, rest_empty;
	logic [POINTS-1:0] word;

	assign word      = (cmd == CMD_CLEAR) ? '0 : new_bits[POINTS-1:0];
	assign type_ok   = int'(prot_type) < TYPES;
	assign slot_free = !out_valid_q || !out_stall;
	assign rest_empty = (diff_q[POINTS-1:1] == '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && type_ok) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if ((diff_q == '0) || (advance && rest_empty)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall = 1'b1;
		emit     = 1'b0;
		advance  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_SCAN: begin
				emit    = diff_q[0] && slot_free;
				advance = (diff_q != '0) && (!diff_q[0] || slot_free);
			end
			default: in_stall = 1'b1;
		endcase
	end

	assign accept   = in_valid && !in_stall;
	assign wr.en    = accept && type_ok;
	assign wr.sel   = prot_type;
	assign wr.data  = word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// shift unit: one point per cycle when not stalled, bit 0 is the point at idx_q
	always_ff @(posedge clk) begin
		if (accept && type_ok) begin
			diff_q <= (rd_mask ^ word) & limit_mask(pc);
			word_q <= word;
			type_q <= prot_type;
			idx_q  <= '0;
		end else if (advance) begin
			diff_q <= diff_q >> 1;
			idx_q  <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ev_type_q <= type_q;
			pidx_q    <= idx_q;
			nval_q    <= word_q[idx_q];
			mask_q    <= word_q;
			last_q    <= rest_empty;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_type  = ev_type_q;
	assign point_index = pidx_q;
	assign new_value   = nval_q;
	assign mask_after  = WORD_W'(mask_q);
	assign last        = last_q;

endmodule

[rtl/bitmask_change_event_emitter_core.sv]
`timescale 1ns / 1ps
// The word is taken into the shift register, which walks its change bits; the event for
// point p is then loaded into the output register, and a stalled output side holds it.
// The input stays closed until the scan of a word is through; a word with no reported
// change still starts a scan, and one with an unknown type leaves the input open.
// One shift register walks the change bits one point per cycle; a stalled event holds it.
// Reset clears all masks, sets point_count to 64 and empties the output register.

module bitmask_change_event_emitter_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bcee_pkg::CNT_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [bcee_pkg::TYPE_W-1:0] prot_type,
	input  logic [bcee_pkg::WORD_W-1:0] new_bits,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bcee_pkg::TYPE_W-1:0] event_type,
	output logic [bcee_pkg::IDX_W-1:0]  point_index,
	output logic                        new_value,
	output logic [bcee_pkg::WORD_W-1:0] mask_after,
	output logic                        last
);
	import bcee_pkg::*;

	logic [CNT_W-1:0]  pc_q;
	mask_wr_t          wr;
	logic [POINTS-1:0] rd_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= CNT_W'(POINTS);
		end else if (cfg_we) begin
			pc_q <= clamp_count(cfg_wdata);
		end
	end

	bcee_mask_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_sel  (prot_type),
		.rd_mask (rd_mask)
	);

	bcee_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.pc          (pc_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.prot_type   (prot_type),
		.new_bits    (new_bits),
		.rd_mask     (rd_mask),
		.wr          (wr),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_type  (event_type),
		.point_index (point_index),
		.new_value   (new_value),
		.mask_after  (mask_after),
		.last        (last)
	);

endmodule

[rtl/bcee_checker.sv]
`timescale 1ns / 1ps

module bcee_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [bcee_pkg::TYPE_W-1:0] prot_type,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [bcee_pkg::TYPE_W-1:0] event_type,
	input logic [bcee_pkg::IDX_W-1:0]  point_index,
	input logic                        last
);
	import bcee_pkg::*;

	// a held event word keeps its point
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(point_index))
		else $error("stalled event word changed");

	// more events pending for this word keep the input side closed
	a_busy_until_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |-> in_stall)
		else $error("input opened before last event");

	// a known type starts a scan
	a_scan_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (int'(prot_type) < TYPES) |=> in_stall)
		else $error("scan did not start");

	// an unknown type is dropped at once
	a_bad_type_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (int'(prot_type) >= TYPES) |=> !in_stall)
		else $error("unknown type held the input");

	a_event_type_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(event_type) < TYPES))
		else $error("event of unknown type");

endmodule

bind bitmask_change_event_emitter_core bcee_checker u_chk (.*);
